FILE: rtl/core/tet_pkg.sv
// ----------------------------------------------------------------------------
// tet_pkg
// Shared types and constants of the token expiry table: table size, field
// widths, operation codes and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package tet_pkg;

   localparam int NUM_TOKENS = 256;
   localparam int IDX_W      = $clog2(NUM_TOKENS);
   localparam int OP_W       = 2;
   localparam int ID_W       = 8;
   localparam int TIME_W     = 31;
   localparam int EXP_W      = 32;
   localparam int COUNT_W    = 9;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [TIME_W-1:0]  TTL_RESET = TIME_W'(1);

   typedef enum logic [OP_W-1:0] {
      OP_GENERATE = 2'd0,
      OP_RENEW    = 2'd1,
      OP_COUNT    = 2'd2
   } op_type;

   typedef struct packed {
      logic latch;
      logic scan_clear;
      logic wr_gen;
      logic rd_id;
      logic wr_renew;
      logic scan_rd;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic id_ok;
      logic scan_last;
      logic out_free;
   } sts_type;

endpackage

FILE: rtl/core/tet_datapath.sv
// ----------------------------------------------------------------------------
// tet_datapath
// Holds the ttl register, the slot valid bits, the expiry memory, the scan
// address and live counter, and the result register.
// ----------------------------------------------------------------------------
module tet_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [tet_pkg::ID_W-1:0]      req_token_id,
   input  logic [tet_pkg::TIME_W-1:0]    req_current_time,
   input  logic                          csr_valid,
   input  logic [tet_pkg::TIME_W-1:0]    csr_ttl,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output logic [tet_pkg::COUNT_W-1:0]   rsp_live_count,
   input  tet_pkg::cmd_type              cmd,
   output tet_pkg::sts_type              sts
);
   import tet_pkg::*;

   logic [EXP_W-1:0]    expiry_mem [NUM_TOKENS];
   logic [NUM_TOKENS-1:0] slot_valid_ff, slot_valid_in;
   logic [TIME_W-1:0]   ttl_ff, ttl_in;
   logic [IDX_W-1:0]    id_ff;
   logic [TIME_W-1:0]   now_ff;
   logic [IDX_W-1:0]    scan_addr_ff, scan_addr_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                acc_ff;
   logic [EXP_W-1:0]    rdata_ff;
   logic                rvalid_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic [IDX_W-1:0]    rd_addr;
   logic [EXP_W-1:0]    new_expiry;
   logic                live_hit;
   logic                wr_en;

   assign new_expiry = EXP_W'({1'b0, now_ff}) + EXP_W'({1'b0, ttl_ff});
   assign rd_addr    = cmd.rd_id ? id_ff : scan_addr_ff;
   assign live_hit   = rvalid_ff && (rdata_ff > EXP_W'({1'b0, now_ff}));
   assign wr_en      = cmd.wr_gen || (cmd.wr_renew && live_hit);

   assign sts.id_ok     = (32'(req_token_id) < NUM_TOKENS);
   assign sts.scan_last = (scan_addr_ff == IDX_W'(NUM_TOKENS - 1));
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_live_count = rsp_count_ff;

   always_comb begin
      ttl_in = csr_valid ? csr_ttl : ttl_ff;

      slot_valid_in = slot_valid_ff;
      if (cmd.wr_gen) begin
         slot_valid_in[id_ff] = 1'b1;
      end

      scan_addr_in = scan_addr_ff;
      if (cmd.scan_clear) begin
         scan_addr_in = '0;
      end else if (cmd.scan_rd) begin
         scan_addr_in = scan_addr_ff + IDX_W'(1);
      end

      count_in = count_ff;
      if (cmd.scan_clear) begin
         count_in = '0;
      end else if (acc_ff && live_hit && (count_ff != COUNT_MAX)) begin
         count_in = count_ff + COUNT_W'(1);
      end

      rsp_valid_in = cmd.load_out || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ttl_ff        <= TTL_RESET;
         slot_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         acc_ff        <= 1'b0;
      end else begin
         ttl_ff        <= ttl_in;
         slot_valid_ff <= slot_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         acc_ff        <= cmd.scan_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         id_ff  <= IDX_W'(req_token_id);
         now_ff <= req_current_time;
      end
      scan_addr_ff <= scan_addr_in;
      count_ff     <= count_in;
      if (cmd.load_out) begin
         rsp_count_ff <= count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         expiry_mem[id_ff] <= new_expiry;
      end
      rdata_ff  <= expiry_mem[rd_addr];
      rvalid_ff <= slot_valid_ff[rd_addr];
   end

endmodule

FILE: rtl/core/tet_ctrl.sv
// ----------------------------------------------------------------------------
// tet_ctrl
// Controller state machine of the token expiry table. It accepts requests,
// sequences generate, renew and count operations and hands the count to the
// result register.
// ----------------------------------------------------------------------------
module tet_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [tet_pkg::OP_W-1:0]    req_operation,
   output tet_pkg::cmd_type            cmd,
   input  tet_pkg::sts_type            sts
);
   import tet_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE      = 7'b0000001,
      ST_GEN       = 7'b0000010,
      ST_REN_RD    = 7'b0000100,
      ST_REN_WR    = 7'b0001000,
      ST_CNT_RUN   = 7'b0010000,
      ST_CNT_DRAIN = 7'b0100000,
      ST_CNT_OUT   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.latch = 1'b1;
               case (req_operation)
                  OP_GENERATE: begin
                     state_in = sts.id_ok ? ST_GEN : ST_IDLE;
                  end
                  OP_RENEW: begin
                     state_in = sts.id_ok ? ST_REN_RD : ST_IDLE;
                  end
                  default: begin
                     cmd.scan_clear = 1'b1;
                     state_in       = ST_CNT_RUN;
                  end
               endcase
            end
         end
         ST_GEN: begin
            cmd.wr_gen = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_REN_RD: begin
            cmd.rd_id = 1'b1;
            state_in  = ST_REN_WR;
         end
         ST_REN_WR: begin
            cmd.wr_renew = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_CNT_RUN: begin
            cmd.scan_rd = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_CNT_DRAIN;
            end
         end
         ST_CNT_DRAIN: begin
            state_in = ST_CNT_OUT;
         end
         ST_CNT_OUT: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/core/token_expiry_table.sv
// ----------------------------------------------------------------------------
// token_expiry_table
// A table of token slots with a valid bit and an expiry time each. Generate
// stores time + ttl, renew refreshes a live slot, and count returns the
// number of slots still live at the given time.
//
//   Channel   Direction  Handshake        Payload
//   req_      in         valid / stall    operation, token_id, current_time
//   rsp_      out        valid / stall    live_count (count requests only)
//   csr_      in         valid / ready    ttl
//
// Renew reads the expiry memory through a registered read before it writes
// back; generate writes without a read. Count scans the table and reads one
// memory entry per cycle. Synchronous reset clears all valid bits and sets
// ttl to 1. A stalled result waits in the output register while the next
// request is taken; a later count holds until that transfer.
// ----------------------------------------------------------------------------
module token_expiry_table (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [tet_pkg::OP_W-1:0]      req_operation,
   input  logic [tet_pkg::ID_W-1:0]      req_token_id,
   input  logic [tet_pkg::TIME_W-1:0]    req_current_time,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tet_pkg::COUNT_W-1:0]   rsp_live_count,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tet_pkg::TIME_W-1:0]    csr_ttl
);
   import tet_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   tet_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .cmd           (cmd),
      .sts           (sts)
   );

   tet_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_token_id     (req_token_id),
      .req_current_time (req_current_time),
      .csr_valid        (csr_valid),
      .csr_ttl          (csr_ttl),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_live_count   (rsp_live_count),
      .cmd              (cmd),
      .sts              (sts)
   );

endmodule
